FILE: hdl/cpu16eu_pkg.sv
// Package with the word types, opcodes and ALU functions of the execute unit.
`timescale 1ns / 1ps

package cpu16eu_pkg;

    localparam int RAM_ADDR_BITS_DEF = 16;
    localparam int REG_COUNT         = 8;
    localparam int REG_IDX_BITS      = 3;
    localparam int DATA_BITS         = 16;

    // ALU operation codes.
    localparam logic [4:0] ALU_ADD  = 5'd0;
    localparam logic [4:0] ALU_SUB  = 5'd1;
    localparam logic [4:0] ALU_AND  = 5'd2;
    localparam logic [4:0] ALU_NOTA = 5'd3;
    localparam logic [4:0] ALU_OR   = 5'd4;
    localparam logic [4:0] ALU_XOR  = 5'd5;
    localparam logic [4:0] ALU_NAND = 5'd6;
    localparam logic [4:0] ALU_NOR  = 5'd7;
    localparam logic [4:0] ALU_SHL  = 5'd8;
    localparam logic [4:0] ALU_SHR  = 5'd9;
    localparam logic [4:0] ALU_GT   = 5'd10;
    localparam logic [4:0] ALU_LT   = 5'd11;
    localparam logic [4:0] ALU_EQ   = 5'd12;

    // Control and memory opcodes.
    localparam logic [4:0] OP_JMP   = 5'b10000;
    localparam logic [4:0] OP_JZ    = 5'b10001;
    localparam logic [4:0] OP_JNZ   = 5'b10010;
    localparam logic [4:0] OP_JC    = 5'b10011;
    localparam logic [4:0] OP_JNC   = 5'b10100;
    localparam logic [4:0] OP_CLK   = 5'b10111;
    localparam logic [4:0] OP_LDI   = 5'b11000;
    localparam logic [4:0] OP_LD    = 5'b11001;
    localparam logic [4:0] OP_ST    = 5'b11010;
    localparam logic [4:0] OP_IN    = 5'b11011;
    localparam logic [4:0] OP_OUT   = 5'b11100;
    localparam logic [4:0] OP_HALT  = 5'b11111;

    // Operand modes.
    localparam logic [1:0] MODE_PRE_A = 2'd0;
    localparam logic [1:0] MODE_PRE_B = 2'd1;
    localparam logic [1:0] MODE_IMM_A = 2'd2;
    localparam logic [1:0] MODE_IMM_B = 2'd3;

    // Stop causes.
    localparam logic [1:0] STOP_RUN     = 2'd0;
    localparam logic [1:0] STOP_HALT    = 2'd1;
    localparam logic [1:0] STOP_ILLEGAL = 2'd2;

    typedef struct packed {
        logic        is_alu_op;
        logic [4:0]  opcode;
        logic [2:0]  dest_reg;
        logic [2:0]  src_a_reg;
        logic [2:0]  src_b_reg;
        logic [1:0]  operand_mode;
        logic [7:0]  alu_byte;
        logic [15:0] body_word;
    } t_in_word;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        reg_write_valid;
        logic [2:0]  reg_write_index;
        logic [15:0] reg_write_value;
        logic        carry_out;
        logic        clock_pulse;
        logic [1:0]  stop_cause;
    } t_out_word;

    function automatic logic [15:0] alu_calc(input logic [4:0] code,
                                             input logic [15:0] a,
                                             input logic [15:0] b);
        logic [15:0] res;
        case (code)
            ALU_ADD:  res = a + b;
            ALU_SUB:  res = a - b;
            ALU_AND:  res = a & b;
            ALU_NOTA: res = ~a;
            ALU_OR:   res = a | b;
            ALU_XOR:  res = a ^ b;
            ALU_NAND: res = ~(a & b);
            ALU_NOR:  res = ~(a | b);
            ALU_SHL:  res = (b[15:4] != 12'd0) ? 16'd0 : (a << b[3:0]);
            ALU_SHR:  res = (b[15:4] != 12'd0) ? 16'd0 : (a >> b[3:0]);
            ALU_GT:   res = {15'd0, (a > b)};
            ALU_LT:   res = {15'd0, (a < b)};
            ALU_EQ:   res = {15'd0, (a == b)};
            default:  res = a;
        endcase
        return res;
    endfunction

    function automatic logic alu_carry(input logic [4:0] code,
                                       input logic [15:0] a,
                                       input logic [15:0] b);
        logic [16:0] sum;
        logic        c;
        sum = {1'b0, a} + {1'b0, b};
        case (code)
            ALU_ADD: c = sum[16];
            ALU_SUB: c = (b > a);
            default: c = 1'b0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/cpu16_execute_unit_core.sv
// Execute unit of a 16-bit CPU: register file, data RAM, program counter and flags.
//
// An instruction word enters on the input channel (i_in_valid / o_in_ready) and one
// result word leaves on the output channel (o_out_valid / i_out_ready) for each one.
// The register file lives in four copies of an 8-entry RAM, one per read port
// (operand a, operand b, pre-operation register, store data); the data RAM holds
// 2**RAM_ADDR_BITS words. Reads are issued when a word is accepted and the
// instruction executes and writes back as it leaves the execute stage, with forwarding
// from the instruction that wrote back in the same cycle as the reads.
// The result word passes the execute stage register and then the output register,
// and one word is accepted per cycle while the receiver keeps taking results.
// When the receiver stalls, the output register holds its word, one more word may
// sit in the execute stage, and then input ready drops.
// Reset clears the program counter, flags, stop cause and the register file, which
// then reads as zero; data RAM contents stay undefined until written.
// After a halt or an illegal opcode every further word returns the held state.
`timescale 1ns / 1ps

module cpu16_execute_unit_core
    import cpu16eu_pkg::*;
#(
    parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int RAM_DEPTH = 2 ** RAM_ADDR_BITS;
    localparam int NPORTS    = 4;
    localparam int PORT_A    = 0;
    localparam int PORT_B    = 1;
    localparam int PORT_P    = 2;
    localparam int PORT_D    = 3;

    logic                     in_accept;
    logic                     s1_commit;

    logic                     r_s1_valid;
    t_in_word                 r_s1_word;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic [15:0]              r_pc;
    logic [15:0]              r_last;
    logic                     r_carry;
    logic [1:0]               r_stop_code;
    logic [REG_COUNT-1:0]     r_rf_vld;

    logic                     r_rfw_valid;
    logic [REG_IDX_BITS-1:0]  r_rfw_idx;
    logic [15:0]              r_rfw_val;
    logic                     r_mfw_valid;
    logic [RAM_ADDR_BITS-1:0] r_mfw_addr;
    logic [15:0]              r_mfw_val;

    logic [REG_IDX_BITS-1:0]  rf_raddr_in [NPORTS];
    logic [REG_IDX_BITS-1:0]  rf_raddr_s1 [NPORTS];
    logic [15:0]              rf_q [NPORTS];
    logic [15:0]              rf_val [NPORTS];
    logic [15:0]              dram_q;
    logic [15:0]              dram_val;
    logic [RAM_ADDR_BITS-1:0] s1_addr;

    logic                     rf_we;
    logic                     dram_we;
    logic [15:0]              pre_b;
    logic [15:0]              op_a;
    logic [15:0]              op_b;
    logic [15:0]              alu_res;

    logic [15:0]              n_pc;
    logic [15:0]              n_last;
    logic                     n_carry;
    logic [1:0]               n_stop_code;
    logic                     n_wr;
    logic [15:0]              n_wval;
    logic                     n_pulse;
    logic                     n_store;
    t_out_word                n_out;

    assign s1_commit  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_commit;
    assign in_accept  = i_in_valid && o_in_ready;
    assign s1_addr    = r_s1_word.body_word[RAM_ADDR_BITS-1:0];

    always_comb begin
        rf_raddr_in[PORT_A] = i_in_word.src_a_reg;
        rf_raddr_in[PORT_B] = i_in_word.src_b_reg;
        rf_raddr_in[PORT_P] = i_in_word.alu_byte[3:1];
        rf_raddr_in[PORT_D] = i_in_word.dest_reg;
        rf_raddr_s1[PORT_A] = r_s1_word.src_a_reg;
        rf_raddr_s1[PORT_B] = r_s1_word.src_b_reg;
        rf_raddr_s1[PORT_P] = r_s1_word.alu_byte[3:1];
        rf_raddr_s1[PORT_D] = r_s1_word.dest_reg;
    end

    for (genvar k = 0; k < NPORTS; k++) begin : g_rf
        cpu16eu_ram #(
            .WIDTH(DATA_BITS),
            .DEPTH(REG_COUNT)
        ) u_rf (
            .i_clk    (i_clk),
            .i_wr_en  (rf_we),
            .i_wr_addr(r_s1_word.dest_reg),
            .i_wr_data(n_wval),
            .i_rd_en  (in_accept),
            .i_rd_addr(rf_raddr_in[k]),
            .o_rd_data(rf_q[k])
        );
    end

    cpu16eu_ram #(
        .WIDTH(DATA_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_dram (
        .i_clk    (i_clk),
        .i_wr_en  (dram_we),
        .i_wr_addr(s1_addr),
        .i_wr_data(rf_val[PORT_D]),
        .i_rd_en  (in_accept),
        .i_rd_addr(i_in_word.body_word[RAM_ADDR_BITS-1:0]),
        .o_rd_data(dram_q)
    );

    // A register that was never written reads as zero.
    always_comb begin
        for (int k = 0; k < NPORTS; k++) begin
            if (r_rfw_valid && (r_rfw_idx == rf_raddr_s1[k])) begin
                rf_val[k] = r_rfw_val;
            end else if (r_rf_vld[rf_raddr_s1[k]]) begin
                rf_val[k] = rf_q[k];
            end else begin
                rf_val[k] = 16'd0;
            end
        end
        dram_val = (r_mfw_valid && (r_mfw_addr == s1_addr)) ? r_mfw_val : dram_q;
    end

    always_comb begin
        pre_b = r_s1_word.alu_byte[0] ? {13'd0, r_s1_word.alu_byte[3:1]} : rf_val[PORT_P];
        op_a  = rf_val[PORT_A];
        op_b  = rf_val[PORT_B];
        case (r_s1_word.operand_mode)
            MODE_PRE_A: begin
                op_a = alu_calc({1'b0, r_s1_word.alu_byte[7:4]}, rf_val[PORT_A], pre_b);
            end
            MODE_PRE_B: begin
                op_b = alu_calc({1'b0, r_s1_word.alu_byte[7:4]},
                                {13'd0, r_s1_word.src_b_reg}, pre_b);
            end
            MODE_IMM_A: begin
                op_a = {8'd0, r_s1_word.alu_byte};
            end
            MODE_IMM_B: begin
                op_b = {8'd0, r_s1_word.alu_byte};
            end
            default: begin
                op_a = rf_val[PORT_A];
            end
        endcase
        alu_res = alu_calc(r_s1_word.opcode, op_a, op_b);
    end

    always_comb begin
        n_pc        = r_pc;
        n_last      = r_last;
        n_carry     = r_carry;
        n_stop_code = r_stop_code;
        n_wr        = 1'b0;
        n_wval      = 16'd0;
        n_pulse     = 1'b0;
        n_store     = 1'b0;
        if (r_stop_code == STOP_RUN) begin
            n_pc = r_pc + 16'd1;
            if (r_s1_word.is_alu_op) begin
                n_carry = alu_carry(r_s1_word.opcode, op_a, op_b);
                n_last  = alu_res;
                n_wr    = 1'b1;
                n_wval  = alu_res;
            end else begin
                case (r_s1_word.opcode)
                    OP_JMP: begin
                        n_pc = r_s1_word.body_word;
                    end
                    OP_JZ: begin
                        if (r_last == 16'd0) begin
                            n_pc = r_s1_word.body_word;
                        end
                    end
                    OP_JNZ: begin
                        if (r_last != 16'd0) begin
                            n_pc = r_s1_word.body_word;
                        end
                    end
                    OP_JC: begin
                        if (r_carry) begin
                            n_pc = r_s1_word.body_word;
                        end
                    end
                    OP_JNC: begin
                        if (!r_carry) begin
                            n_pc = r_s1_word.body_word;
                        end
                    end
                    OP_CLK: begin
                        n_pulse = 1'b1;
                    end
                    OP_LDI: begin
                        n_wr   = 1'b1;
                        n_wval = r_s1_word.body_word;
                    end
                    OP_LD: begin
                        n_wr   = 1'b1;
                        n_wval = dram_val;
                    end
                    OP_ST: begin
                        n_store = 1'b1;
                    end
                    OP_IN, OP_OUT: begin
                        n_pulse = 1'b0;
                    end
                    OP_HALT: begin
                        n_stop_code = STOP_HALT;
                    end
                    default: begin
                        n_stop_code = STOP_ILLEGAL;
                    end
                endcase
            end
        end
        n_out.next_pc         = n_pc;
        n_out.reg_write_valid = n_wr;
        n_out.reg_write_index = n_wr ? r_s1_word.dest_reg : 3'd0;
        n_out.reg_write_value = n_wval;
        n_out.carry_out       = n_carry;
        n_out.clock_pulse     = n_pulse;
        n_out.stop_cause      = n_stop_code;
    end

    assign rf_we   = s1_commit && n_wr;
    assign dram_we = s1_commit && n_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= 16'd0;
            r_last      <= 16'd0;
            r_carry     <= 1'b0;
            r_stop_code <= STOP_RUN;
            r_rf_vld    <= '0;
            r_rfw_valid <= 1'b0;
            r_mfw_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid  <= 1'b1;
                r_rfw_valid <= rf_we;
                r_mfw_valid <= dram_we;
            end else if (s1_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_commit) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
                r_last      <= n_last;
                r_carry     <= n_carry;
                r_stop_code <= n_stop_code;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[r_s1_word.dest_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_word  <= i_in_word;
            r_rfw_idx  <= r_s1_word.dest_reg;
            r_rfw_val  <= n_wval;
            r_mfw_addr <= s1_addr;
            r_mfw_val  <= rf_val[PORT_D];
        end
        if (s1_commit) begin
            r_out_word <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_stop_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop_code != STOP_RUN) |=> $stable(r_pc))
        else $error("Program counter moved while stopped.");

    a_s1_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_commit) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("Execute stage lost its word during a stall.");

    a_no_write_when_stopping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.reg_write_valid) |-> (r_out_word.stop_cause == STOP_RUN))
        else $error("Register write reported with a stop cause.");

    a_no_write_while_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop_code != STOP_RUN) |-> (!rf_we && !dram_we))
        else $error("State written while stopped.");

endmodule

FILE: hdl/cpu16eu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module cpu16eu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sim/cpu16_execute_unit_core_tb.sv
// Self-checking testbench that runs instruction words through the execute unit core.
`timescale 1ns / 1ps

module cpu16_execute_unit_core_tb;
    import cpu16eu_pkg::*;

    localparam int         RANDOM_WORDS = 1300;
    localparam int         QUIET_FROM   = 600;
    localparam int         QUIET_TO     = 900;
    localparam int         HOLD_AT_A    = 300;
    localparam int         HOLD_AT_B    = 1200;
    localparam int         HOLD_CYCLES  = 80;
    localparam logic [3:0] PRE_PASS     = 4'd15;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    t_in_word    pending_words[$];
    logic [15:0] stored_addrs[$];
    bit          gen_stopped = 1'b0;

    logic [15:0] cpu_regs [REG_COUNT];
    logic [15:0] ram_image [int];
    logic [15:0] cpu_pc         = '0;
    logic [15:0] last_result    = '0;
    logic        cpu_carry      = 1'b0;
    logic        cpu_stopped    = 1'b0;
    logic [1:0]  cpu_stop_cause = STOP_RUN;
    t_out_word   expected_results[$];

    int cycle_cnt  = 0;
    int err_count  = 0;
    bit word_taken = 1'b0;
    int hold_left  = 0;

    cpu16_execute_unit_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] alu_result(input logic [4:0] code,
                                               input logic [15:0] a,
                                               input logic [15:0] b);
        logic [15:0] r;
        case (code)
            ALU_ADD:  r = a + b;
            ALU_SUB:  r = a - b;
            ALU_AND:  r = a & b;
            ALU_NOTA: r = ~a;
            ALU_OR:   r = a | b;
            ALU_XOR:  r = a ^ b;
            ALU_NAND: r = ~(a & b);
            ALU_NOR:  r = ~(a | b);
            ALU_SHL:  r = (b > 16'd15) ? 16'd0 : a << b;
            ALU_SHR:  r = (b > 16'd15) ? 16'd0 : a >> b;
            ALU_GT:   r = (a > b) ? 16'd1 : 16'd0;
            ALU_LT:   r = (a < b) ? 16'd1 : 16'd0;
            ALU_EQ:   r = (a == b) ? 16'd1 : 16'd0;
            default:  r = a;
        endcase
        return r;
    endfunction

    function automatic void predict_word(input t_in_word w);
        t_out_word   res;
        logic [15:0] opa;
        logic [15:0] opb;
        logic [15:0] pre_val;
        logic [15:0] val;
        logic [16:0] sum;
        res = '0;
        val = '0;
        if (!cpu_stopped) begin
            cpu_pc = cpu_pc + 16'd1;
            if (w.is_alu_op) begin
                pre_val = w.alu_byte[0] ? {13'd0, w.alu_byte[3:1]} : cpu_regs[w.alu_byte[3:1]];
                opa = cpu_regs[w.src_a_reg];
                opb = cpu_regs[w.src_b_reg];
                case (w.operand_mode)
                    MODE_PRE_A: opa = alu_result({1'b0, w.alu_byte[7:4]}, opa, pre_val);
                    MODE_PRE_B: opb = alu_result({1'b0, w.alu_byte[7:4]},
                                                 {13'd0, w.src_b_reg}, pre_val);
                    MODE_IMM_A: opa = {8'd0, w.alu_byte};
                    default:    opb = {8'd0, w.alu_byte};
                endcase
                val = alu_result(w.opcode, opa, opb);
                sum = {1'b0, opa} + {1'b0, opb};
                if (w.opcode == ALU_ADD) cpu_carry = sum[16];
                else if (w.opcode == ALU_SUB) cpu_carry = (opb > opa);
                else cpu_carry = 1'b0;
                last_result = val;
                res.reg_write_valid = 1'b1;
            end else begin
                case (w.opcode)
                    OP_JMP: cpu_pc = w.body_word;
                    OP_JZ:  if (last_result == '0) cpu_pc = w.body_word;
                    OP_JNZ: if (last_result != '0) cpu_pc = w.body_word;
                    OP_JC:  if (cpu_carry) cpu_pc = w.body_word;
                    OP_JNC: if (!cpu_carry) cpu_pc = w.body_word;
                    OP_CLK: res.clock_pulse = 1'b1;
                    OP_LDI: begin
                        val = w.body_word;
                        res.reg_write_valid = 1'b1;
                    end
                    OP_LD: begin
                        val = ram_image[w.body_word];
                        res.reg_write_valid = 1'b1;
                    end
                    OP_ST:  ram_image[w.body_word] = cpu_regs[w.dest_reg];
                    OP_IN, OP_OUT: ;
                    OP_HALT: begin
                        cpu_stopped = 1'b1;
                        cpu_stop_cause = STOP_HALT;
                    end
                    default: begin
                        cpu_stopped = 1'b1;
                        cpu_stop_cause = STOP_ILLEGAL;
                    end
                endcase
            end
            if (res.reg_write_valid) begin
                cpu_regs[w.dest_reg] = val;
                res.reg_write_index = w.dest_reg;
                res.reg_write_value = val;
            end
        end
        res.next_pc    = cpu_pc;
        res.carry_out  = cpu_carry;
        res.stop_cause = cpu_stop_cause;
        expected_results.push_back(res);
    endfunction

    function automatic bit ctrl_known(input logic [4:0] op);
        case (op)
            OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_CLK,
            OP_LDI, OP_LD, OP_ST, OP_IN, OP_OUT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void queue_word(input t_in_word w);
        if (!gen_stopped && !w.is_alu_op) begin
            if (w.opcode == OP_ST) stored_addrs.push_back(w.body_word);
            else if (!ctrl_known(w.opcode)) gen_stopped = 1'b1;
        end
        pending_words.push_back(w);
    endfunction

    function automatic t_in_word noise_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word ctrl_word(input logic [4:0] op, input logic [2:0] dst,
                                           input logic [15:0] body);
        t_in_word w;
        w = noise_word();
        w.is_alu_op = 1'b0;
        w.opcode    = op;
        w.dest_reg  = dst;
        w.body_word = body;
        return w;
    endfunction

    function automatic t_in_word alu_word(input logic [4:0] op, input logic [2:0] dst,
                                          input logic [2:0] ra, input logic [2:0] rb,
                                          input logic [1:0] mode, input logic [7:0] abyte);
        t_in_word w;
        w = noise_word();
        w.is_alu_op    = 1'b1;
        w.opcode       = op;
        w.dest_reg     = dst;
        w.src_a_reg    = ra;
        w.src_b_reg    = rb;
        w.operand_mode = mode;
        w.alu_byte     = abyte;
        return w;
    endfunction

    function automatic logic [15:0] extreme_value();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        int          pick;
        logic [15:0] addr;
        logic [4:0]  op;
        w = noise_word();
        pick = $urandom_range(99);
        if (pick < 45) begin
            w.is_alu_op = 1'b1;
            if ($urandom_range(99) < 85) w.opcode = 5'($urandom_range(ALU_EQ));
        end else if (pick < 60) begin
            w = ctrl_word(OP_LDI, w.dest_reg,
                          ($urandom_range(3) == 0) ? extreme_value() : w.body_word);
        end else if (pick < 68 || (pick < 76 && stored_addrs.size() == 0)) begin
            addr = w.body_word;
            if (stored_addrs.size() != 0 && $urandom_range(1))
                addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
            w = ctrl_word(OP_ST, w.dest_reg, addr);
        end else if (pick < 76) begin
            w = ctrl_word(OP_LD, w.dest_reg,
                          stored_addrs[$urandom_range(stored_addrs.size() - 1)]);
        end else begin
            if (pick < 92) begin
                case ($urandom_range(4))
                    0:       op = OP_JMP;
                    1:       op = OP_JZ;
                    2:       op = OP_JNZ;
                    3:       op = OP_JC;
                    default: op = OP_JNC;
                endcase
            end else if (pick < 96) begin
                op = OP_CLK;
            end else begin
                op = $urandom_range(1) ? OP_IN : OP_OUT;
            end
            w = ctrl_word(op, w.dest_reg, w.body_word);
        end
        return w;
    endfunction

    function automatic bit take_break();
        return ($urandom_range(99) < 15) && !(cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO);
    endfunction

    initial begin
        int         k;
        logic [4:0] op;
        foreach (cpu_regs[i]) cpu_regs[i] = '0;

        queue_word(ctrl_word(OP_LDI, 3'd1, 16'hFFFF));
        queue_word(ctrl_word(OP_LDI, 3'd2, 16'h0001));
        queue_word(alu_word(ALU_ADD, 3'd3, 3'd1, 3'd2, MODE_PRE_A, {PRE_PASS, 4'd0}));
        queue_word(ctrl_word(OP_JC, 3'd0, 16'hFFFF));
        queue_word(alu_word(ALU_SUB, 3'd4, 3'd2, 3'd1, MODE_PRE_A, {PRE_PASS, 4'd0}));
        for (k = ALU_AND; k <= ALU_EQ; k++)
            queue_word(alu_word(k[4:0], 3'd5, 3'd1, 3'($urandom_range(7)),
                                2'($urandom_range(MODE_IMM_B, MODE_IMM_A)),
                                8'($urandom_range(255))));
        queue_word(alu_word(ALU_SHL, 3'd5, 3'd1, 3'd0, MODE_IMM_B, 8'd16));
        queue_word(alu_word(ALU_SHR, 3'd5, 3'd1, 3'd0, MODE_IMM_B, 8'd255));
        queue_word(alu_word(ALU_OR, 3'd6, 3'd1, 3'd0, MODE_PRE_A, {ALU_ADD[3:0], 3'd4, 1'b0}));
        queue_word(alu_word(ALU_ADD, 3'd6, 3'd0, 3'd7, MODE_PRE_B, {ALU_XOR[3:0], 3'd5, 1'b1}));
        queue_word(alu_word(ALU_ADD, 3'd7, 3'd2, 3'd3, MODE_PRE_B, {ALU_ADD[3:0], 3'd1, 1'b0}));
        queue_word(alu_word(5'($urandom_range(5'h1F, ALU_EQ + 1)), 3'd0, 3'd1, 3'd2,
                            MODE_IMM_B, 8'hA5));
        queue_word(ctrl_word(OP_JZ, 3'd0, 16'h1234));
        queue_word(ctrl_word(OP_JNZ, 3'd0, 16'h8000));
        queue_word(ctrl_word(OP_JMP, 3'd0, 16'h0000));
        queue_word(ctrl_word(OP_ST, 3'd1, 16'hFFFF));
        queue_word(ctrl_word(OP_ST, 3'd4, 16'h0000));
        queue_word(ctrl_word(OP_LD, 3'd6, 16'hFFFF));
        queue_word(ctrl_word(OP_LD, 3'd7, 16'h0000));
        queue_word(ctrl_word(OP_CLK, 3'd0, 16'h0000));
        queue_word(ctrl_word(OP_IN, 3'd0, 16'h0000));
        queue_word(ctrl_word(OP_OUT, 3'd0, 16'h0000));
        repeat (RANDOM_WORDS) queue_word(random_word());

        // The core can stop only once: a halt or an illegal opcode precedes the final words.
        if ($urandom_range(1)) begin
            op = OP_HALT;
        end else begin
            do op = 5'($urandom_range(5'h1F)); while (ctrl_known(op) || op == OP_HALT);
        end
        queue_word(ctrl_word(op, 3'($urandom_range(7)), 16'($urandom)));
        repeat (6) queue_word(random_word());

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (pending_words.size() != 0 && !take_break()) begin
                i_in_word  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B) begin
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && !take_break();
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            cycle_cnt  <= cycle_cnt + 1;
            word_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no instruction pending, next_pc %h",
                           o_out_word.next_pc);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_word.next_pc !== want.next_pc) begin
                        $error("next_pc: expected %h, got %h", want.next_pc, o_out_word.next_pc);
                        err_count++;
                    end
                    if (o_out_word.reg_write_valid !== want.reg_write_valid) begin
                        $error("reg_write_valid: expected %b, got %b",
                               want.reg_write_valid, o_out_word.reg_write_valid);
                        err_count++;
                    end
                    if (o_out_word.reg_write_index !== want.reg_write_index) begin
                        $error("reg_write_index: expected %0d, got %0d",
                               want.reg_write_index, o_out_word.reg_write_index);
                        err_count++;
                    end
                    if (o_out_word.reg_write_value !== want.reg_write_value) begin
                        $error("reg_write_value: expected %h, got %h",
                               want.reg_write_value, o_out_word.reg_write_value);
                        err_count++;
                    end
                    if (o_out_word.carry_out !== want.carry_out) begin
                        $error("carry_out: expected %b, got %b",
                               want.carry_out, o_out_word.carry_out);
                        err_count++;
                    end
                    if (o_out_word.clock_pulse !== want.clock_pulse) begin
                        $error("clock_pulse: expected %b, got %b",
                               want.clock_pulse, o_out_word.clock_pulse);
                        err_count++;
                    end
                    if (o_out_word.stop_cause !== want.stop_cause) begin
                        $error("stop_cause: expected %0d, got %0d",
                               want.stop_cause, o_out_word.stop_cause);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) predict_word(i_in_word);
        end
    end

endmodule
